// ===== rtl/mls_pkg.sv =====
// package for the marker landing setpoint block
// holds constants, controller state type, datapath command/status structs
package mls_pkg;

   localparam int POS_FRAC_BITS_DEF  = 16;
   localparam int QUAT_FRAC_BITS_DEF = 14;
   localparam int CM_W   = 23;
   localparam int CFG_W  = 32;
   localparam int IDX_W  = 3;
   localparam int STEP_W = 4;
   localparam logic signed [CM_W-1:0] CM_LIMIT = 23'sd3276800;

   localparam logic [1:0] MODE_ATT = 2'd0;
   localparam logic [1:0] MODE_POS = 2'd1;
   localparam logic [1:0] MODE_DET = 2'd2;

   localparam logic [IDX_W-1:0] REG_OFF_ALT   = 3'd0;
   localparam logic [IDX_W-1:0] REG_ALIGN     = 3'd1;
   localparam logic [IDX_W-1:0] REG_DESC_MIN  = 3'd2;
   localparam logic [IDX_W-1:0] REG_DESC_STEP = 3'd3;
   localparam logic [IDX_W-1:0] REG_LOCK_PER  = 3'd4;
   localparam logic [IDX_W-1:0] REG_OFFSET_X  = 3'd5;

   // last step of each multi-cycle phase
   localparam logic [STEP_W-1:0] LAST_PROD = 4'd8;
   localparam logic [STEP_W-1:0] LAST_OFFS = 4'd2;
   localparam logic [STEP_W-1:0] LAST_ROT  = 4'd8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PROD,
      ST_MATRIX,
      ST_OFFS,
      ST_SWAP,
      ST_ROT,
      ST_FINISH,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic pos_go;   // store drone position
      logic prod_go;  // one quaternion product
      logic mat_go;   // build matrix entries from products
      logic offs_go;  // one offset product and add
      logic swap_go;  // camera to body swap
      logic rot_go;   // one attitude rotation product
      logic fin_go;   // setpoint update
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic is_att;
      logic is_pos;
      logic is_det;
   } stat_type;

endpackage

// ===== rtl/mls_if.sv =====
// valid/ready channel interface with payload
// depends on nothing
interface mls_if #(parameter int PAYLOAD_W = 8);
   logic valid;
   logic ready;
   logic [PAYLOAD_W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/mls_ctrl.sv =====
// controller state machine for the marker landing setpoint block
// depends on mls_pkg
module mls_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  mls_pkg::stat_type stat,
   output mls_pkg::cmd_type cmd
);
   import mls_pkg::*;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            step_in = '0;
            if (stat.is_att || stat.is_det) state_in = ST_PROD;
            else state_in = ST_IDLE;
         end
         ST_PROD: begin
            if (step_ff == LAST_PROD) begin
               step_in = '0;
               state_in = ST_MATRIX;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_MATRIX: begin
            step_in = '0;
            state_in = stat.is_det ? ST_OFFS : ST_IDLE;
         end
         ST_OFFS: begin
            if (step_ff == LAST_OFFS) begin
               step_in = '0;
               state_in = ST_SWAP;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_SWAP: begin
            step_in = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            if (step_ff == LAST_ROT) begin
               step_in = '0;
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:    if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.step = step_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_DECODE: cmd.pos_go = stat.is_pos;
         ST_PROD:   cmd.prod_go = 1'b1;
         ST_MATRIX: cmd.mat_go = 1'b1;
         ST_OFFS:   cmd.offs_go = 1'b1;
         ST_SWAP:   cmd.swap_go = 1'b1;
         ST_ROT:    cmd.rot_go = 1'b1;
         ST_FINISH: cmd.fin_go = 1'b1;
         ST_OUT:    rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

// ===== rtl/mls_datapath.sv =====
// datapath: state registers, shared multiplier, rotation matrices, setpoint logic
// depends on mls_pkg
module mls_datapath #(
   parameter int POS_FRAC_BITS  = mls_pkg::POS_FRAC_BITS_DEF,
   parameter int QUAT_FRAC_BITS = mls_pkg::QUAT_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  mls_pkg::cmd_type cmd,
   output mls_pkg::stat_type stat,
   input  logic [1:0] mode,
   input  logic signed [31:0] vec_x, vec_y, vec_z,
   input  logic signed [15:0] quat_w, quat_x, quat_y, quat_z,
   input  logic csr_we,
   input  logic [mls_pkg::IDX_W-1:0] csr_index,
   input  logic [mls_pkg::CFG_W-1:0] csr_wdata,
   output logic signed [mls_pkg::CM_W-1:0] setpoint_x_cm, setpoint_y_cm, setpoint_z_cm,
   output logic aligned,
   output logic lock_state
);
   import mls_pkg::*;

   localparam int QF = QUAT_FRAC_BITS;
   localparam int PF = POS_FRAC_BITS;

   // quaternion product slots
   localparam logic [STEP_W-1:0] PRD_XX = 4'd0;
   localparam logic [STEP_W-1:0] PRD_YY = 4'd1;
   localparam logic [STEP_W-1:0] PRD_ZZ = 4'd2;
   localparam logic [STEP_W-1:0] PRD_XY = 4'd3;
   localparam logic [STEP_W-1:0] PRD_WZ = 4'd4;
   localparam logic [STEP_W-1:0] PRD_XZ = 4'd5;
   localparam logic [STEP_W-1:0] PRD_WY = 4'd6;
   localparam logic [STEP_W-1:0] PRD_YZ = 4'd7;
   localparam logic [STEP_W-1:0] PRD_WX = 4'd8;

   logic [30:0] off_alt_ff, align_ff, dmin_ff, dstep_ff;
   logic [7:0]  lock_per_ff;
   logic signed [31:0] offx_ff;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] ra_ff [3][3];   // attitude matrix, identity after reset
   logic lock_ff;
   logic [7:0] cnt_ff;
   logic signed [CM_W-1:0] tgt_ff [3];
   logic signed [CM_W-1:0] alt_ff;
   logic aligned_ff;

   logic [1:0] mode_ff;
   logic signed [31:0] v_ff [3];
   logic signed [15:0] q_ff [4];
   logic signed [31:0] prd_ff [9];
   logic signed [31:0] mm_ff [3];   // first column of marker matrix
   logic signed [31:0] be_ff [3];
   logic signed [63:0] acc_ff;
   logic signed [31:0] af_ff [3];

   assign stat.is_att = (mode_ff == MODE_ATT);
   assign stat.is_pos = (mode_ff == MODE_POS);
   assign stat.is_det = (mode_ff == MODE_DET);

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] rndq(input logic signed [63:0] v);
      return (v + (64'sd1 <<< (QF - 1))) >>> QF;
   endfunction

   function automatic logic signed [CM_W-1:0] to_cm(input logic signed [63:0] v);
      logic signed [63:0] p, c;
      p = v * 64'sd100;
      c = p >>> PF;
      if (p < 0 && (p & ((64'sd1 <<< PF) - 64'sd1)) != 0) c = c + 64'sd1;
      if (c > 64'sd3276800) return CM_LIMIT;
      if (c < -64'sd3276800) return -CM_LIMIT;
      return c[CM_W-1:0];
   endfunction

   // shared multiplier operand select
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic [1:0] row, col;

   always_comb begin
      case (cmd.step)
         4'd0: begin row = 2'd0; col = 2'd0; end
         4'd1: begin row = 2'd0; col = 2'd1; end
         4'd2: begin row = 2'd0; col = 2'd2; end
         4'd3: begin row = 2'd1; col = 2'd0; end
         4'd4: begin row = 2'd1; col = 2'd1; end
         4'd5: begin row = 2'd1; col = 2'd2; end
         4'd6: begin row = 2'd2; col = 2'd0; end
         4'd7: begin row = 2'd2; col = 2'd1; end
         4'd8: begin row = 2'd2; col = 2'd2; end
         default: begin row = 2'd0; col = 2'd0; end
      endcase
      mul_a = '0;
      mul_b = '0;
      if (cmd.prod_go) begin
         case (cmd.step)
            PRD_XX: begin mul_a = 32'(q_ff[1]); mul_b = 32'(q_ff[1]); end
            PRD_YY: begin mul_a = 32'(q_ff[2]); mul_b = 32'(q_ff[2]); end
            PRD_ZZ: begin mul_a = 32'(q_ff[3]); mul_b = 32'(q_ff[3]); end
            PRD_XY: begin mul_a = 32'(q_ff[1]); mul_b = 32'(q_ff[2]); end
            PRD_WZ: begin mul_a = 32'(q_ff[0]); mul_b = 32'(q_ff[3]); end
            PRD_XZ: begin mul_a = 32'(q_ff[1]); mul_b = 32'(q_ff[3]); end
            PRD_WY: begin mul_a = 32'(q_ff[0]); mul_b = 32'(q_ff[2]); end
            PRD_YZ: begin mul_a = 32'(q_ff[2]); mul_b = 32'(q_ff[3]); end
            PRD_WX: begin mul_a = 32'(q_ff[0]); mul_b = 32'(q_ff[1]); end
            default: ;
         endcase
      end else if (cmd.offs_go) begin
         mul_a = mm_ff[cmd.step[1:0]];
         mul_b = offx_ff;
      end else if (cmd.rot_go) begin
         mul_a = ra_ff[row][col];
         mul_b = be_ff[col];
      end
      mul_p = mul_a * mul_b;
   end

   // matrix entries from the stored products
   logic signed [63:0] xx, yy, zz, xy, wz, xz, wy, yz, wx, one_q, er;
   logic signed [63:0] e [3][3];
   logic signed [31:0] ent [3][3];

   always_comb begin
      xx = 64'(prd_ff[PRD_XX]); yy = 64'(prd_ff[PRD_YY]); zz = 64'(prd_ff[PRD_ZZ]);
      xy = 64'(prd_ff[PRD_XY]); wz = 64'(prd_ff[PRD_WZ]); xz = 64'(prd_ff[PRD_XZ]);
      wy = 64'(prd_ff[PRD_WY]); yz = 64'(prd_ff[PRD_YZ]); wx = 64'(prd_ff[PRD_WX]);
      one_q = 64'sd1 <<< (2 * QF);
      e[0][0] = one_q - ((yy + zz) <<< 1);
      e[0][1] = (xy - wz) <<< 1;
      e[0][2] = (xz + wy) <<< 1;
      e[1][0] = (xy + wz) <<< 1;
      e[1][1] = one_q - ((xx + zz) <<< 1);
      e[1][2] = (yz - wx) <<< 1;
      e[2][0] = (xz - wy) <<< 1;
      e[2][1] = (yz + wx) <<< 1;
      e[2][2] = one_q - ((xx + yy) <<< 1);
      er = '0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            er = rndq(e[i][j]);
            ent[i][j] = er[31:0];
         end
   end

   logic low_c;
   logic signed [63:0] off_r;
   logic signed [31:0] off_c, vo_c;
   logic signed [63:0] acc_sum;
   logic al_c;
   logic signed [63:0] ax0, ax1;

   always_comb begin
      low_c = 64'(pos_ff[2]) <= $signed({33'd0, off_alt_ff});
      off_r = rndq(mul_p);
      off_c = sat32(off_r);
      vo_c = sat32(64'(v_ff[cmd.step[1:0]]) + 64'(off_c));
      acc_sum = (col == 2'd0) ? mul_p : acc_ff + mul_p;
      ax0 = af_ff[0] < 0 ? -64'(af_ff[0]) : 64'(af_ff[0]);
      ax1 = af_ff[1] < 0 ? -64'(af_ff[1]) : 64'(af_ff[1]);
      al_c = (ax0 < $signed({33'd0, align_ff})) && (ax1 < $signed({33'd0, align_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_alt_ff <= 31'd196608; align_ff <= 31'd19661;
         dmin_ff <= 31'd32768; dstep_ff <= 31'd131072;
         lock_per_ff <= 8'd70; offx_ff <= -32'sd32768;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            tgt_ff[i] <= '0;
            for (int j = 0; j < 3; j++)
               ra_ff[i][j] <= (i == j) ? (32'sd1 <<< QF) : 32'sd0;
         end
         lock_ff <= 1'b1; cnt_ff <= '0; alt_ff <= 23'sd700;
         aligned_ff <= 1'b0; mode_ff <= 2'd3;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_OFF_ALT:   off_alt_ff <= csr_wdata[30:0];
               REG_ALIGN:     align_ff <= csr_wdata[30:0];
               REG_DESC_MIN:  dmin_ff <= csr_wdata[30:0];
               REG_DESC_STEP: dstep_ff <= csr_wdata[30:0];
               REG_LOCK_PER:  lock_per_ff <= csr_wdata[7:0];
               REG_OFFSET_X:  offx_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) mode_ff <= mode;
         if (cmd.pos_go)
            for (int i = 0; i < 3; i++) pos_ff[i] <= v_ff[i];
         if (cmd.mat_go && mode_ff == MODE_ATT)
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++) ra_ff[i][j] <= ent[i][j];
         if (cmd.fin_go) begin
            if (lock_ff)
               for (int i = 0; i < 3; i++)
                  tgt_ff[i] <= to_cm(64'(af_ff[i]) + 64'(pos_ff[i]));
            aligned_ff <= al_c;
            if (al_c) begin
               if (64'(pos_ff[2]) >= $signed({33'd0, dmin_ff}))
                  alt_ff <= to_cm(64'(pos_ff[2]) - $signed({33'd0, dstep_ff}));
            end else begin
               alt_ff <= to_cm(64'(pos_ff[2]));
            end
            if ({1'b0, cnt_ff} + 9'd1 >= {1'b0, lock_per_ff}) begin
               lock_ff <= 1'b1;
               cnt_ff <= '0;
            end else begin
               if (!al_c) lock_ff <= 1'b0;
               cnt_ff <= cnt_ff + 8'd1;
            end
         end
      end
   end

   // working registers of one request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff[0] <= vec_x; v_ff[1] <= vec_y; v_ff[2] <= vec_z;
         q_ff[0] <= quat_w; q_ff[1] <= quat_x; q_ff[2] <= quat_y; q_ff[3] <= quat_z;
      end else if (cmd.offs_go && low_c) begin
         v_ff[cmd.step[1:0]] <= vo_c;
      end
      if (cmd.prod_go) prd_ff[cmd.step] <= mul_p[31:0];
      if (cmd.mat_go && mode_ff == MODE_DET)
         for (int i = 0; i < 3; i++) mm_ff[i] <= ent[i][0];
      if (cmd.swap_go) begin
         // camera to body swap
         be_ff[0] <= sat32(-64'(v_ff[1]));
         be_ff[1] <= sat32(-64'(v_ff[0]));
         be_ff[2] <= sat32(-64'(v_ff[2]));
      end
      if (cmd.rot_go) begin
         acc_ff <= acc_sum;
         if (col == 2'd2) af_ff[row] <= sat32(rndq(acc_sum));
      end
   end

   assign setpoint_x_cm = tgt_ff[0];
   assign setpoint_y_cm = tgt_ff[1];
   assign setpoint_z_cm = alt_ff;
   assign aligned = aligned_ff;
   assign lock_state = lock_ff;
endmodule

// ===== rtl/marker_landing_setpoint.sv =====
// top level of the marker landing setpoint block
// depends on mls_pkg, mls_if, mls_ctrl, mls_datapath
//
// channel  dir  contents
// req      in   mode, vec_x/y/z, quat_w/x/y/z
// rsp      out  setpoint_x/y/z_cm, aligned, lock_state
// csr      in   write enable, index, data
//
// one request in flight; all quaternion, offset and rotation products go through one shared 32x32 multiplier
// position update or unused mode: accept, decode
// attitude update: accept, decode, 9 products, matrix build
// detection: from accept to earliest response handshake
// (decode, 9 products, matrix, 3 offset products, swap, 9 rotation products, finish)
// reset is synchronous; a stalled response holds its data and blocks requests
module marker_landing_setpoint #(
   parameter int POS_FRAC_BITS  = mls_pkg::POS_FRAC_BITS_DEF,
   parameter int QUAT_FRAC_BITS = mls_pkg::QUAT_FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   mls_if.sink   req,
   mls_if.source rsp,
   input logic csr_we,
   input logic [mls_pkg::IDX_W-1:0] csr_index,
   input logic [mls_pkg::CFG_W-1:0] csr_wdata
);
   import mls_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic signed [CM_W-1:0] sx, sy, sz;
   logic al, lk;

   mls_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat, .cmd
   );

   mls_datapath #(.POS_FRAC_BITS(POS_FRAC_BITS), .QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .stat,
      .mode(req.payload[161:160]),
      .vec_x(req.payload[159:128]), .vec_y(req.payload[127:96]),
      .vec_z(req.payload[95:64]),
      .quat_w(req.payload[63:48]), .quat_x(req.payload[47:32]),
      .quat_y(req.payload[31:16]), .quat_z(req.payload[15:0]),
      .csr_we, .csr_index, .csr_wdata,
      .setpoint_x_cm(sx), .setpoint_y_cm(sy), .setpoint_z_cm(sz),
      .aligned(al), .lock_state(lk)
   );

   assign rsp.payload = {sx, sy, sz, al, lk};
endmodule

// ===== tb/marker_landing_setpoint_tb.sv =====
// testbench for marker_landing_setpoint: random and directed requests, with a scoreboard
// that predicts each setpoint; depends on mls_pkg, mls_if and the block itself
`timescale 1ns / 100ps

module marker_landing_setpoint_tb;
   import mls_pkg::*;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_item_type;

   typedef struct packed {
      logic signed [CM_W-1:0] sp_x;
      logic signed [CM_W-1:0] sp_y;
      logic signed [CM_W-1:0] sp_z;
      logic                   aligned;
      logic                   lock_state;
   } setpoint_type;

   localparam int QF = QUAT_FRAC_BITS_DEF;
   localparam int PF = POS_FRAC_BITS_DEF;

   class setpoint_scoreboard;
      longint off_alt, thr, dmin, dstep, period, offx;
      longint att[4];
      longint pos[3];
      bit lock;
      longint count;
      longint tgt[3];
      longint alt_cm;
      longint mat[3][3];
      setpoint_type setpoints_due[$];
      int errors;

      function new();
         off_alt = 196608; thr = 19661; dmin = 32768; dstep = 131072;
         period = 70; offx = -32768;
         att = '{16384, 0, 0, 0};
         pos = '{0, 0, 0};
         lock = 1; count = 0;
         tgt = '{0, 0, 0};
         alt_cm = 700;
         errors = 0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
         case (idx)
            REG_OFF_ALT:   off_alt = longint'(d[30:0]);
            REG_ALIGN:     thr = longint'(d[30:0]);
            REG_DESC_MIN:  dmin = longint'(d[30:0]);
            REG_DESC_STEP: dstep = longint'(d[30:0]);
            REG_LOCK_PER:  period = longint'(d[7:0]);
            REG_OFFSET_X:  offx = longint'(signed'(d));
            default: ;
         endcase
      endfunction

      function longint rnd(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint to_cm(longint v);
         longint c;
         c = (v * 100) / (64'sd1 <<< PF);
         if (c > 3276800) return 3276800;
         if (c < -3276800) return -3276800;
         return c;
      endfunction

      function longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      // rotation matrix of an unnormalized quaternion, rounded to the quaternion scale
      function void quat_rotation(longint w, longint x, longint y, longint z);
         longint one;
         longint e[3][3];
         one = 64'sd1 <<< (2 * QF);
         e[0][0] = one - 2 * (y * y + z * z);
         e[0][1] = 2 * (x * y - w * z);
         e[0][2] = 2 * (x * z + w * y);
         e[1][0] = 2 * (x * y + w * z);
         e[1][1] = one - 2 * (x * x + z * z);
         e[1][2] = 2 * (y * z - w * x);
         e[2][0] = 2 * (x * z - w * y);
         e[2][1] = 2 * (y * z + w * x);
         e[2][2] = one - 2 * (x * x + y * y);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               mat[i][j] = rnd(e[i][j], QF);
      endfunction

      function void note_request(req_item_type r);
         longint v[3];
         longint be[3];
         longint af[3];
         longint mm[3][3];
         bit al;
         setpoint_type sp;
         case (r.mode)
            MODE_ATT: att = '{r.quat_w, r.quat_x, r.quat_y, r.quat_z};
            MODE_POS: pos = '{r.vec_x, r.vec_y, r.vec_z};
            MODE_DET: begin
               v = '{r.vec_x, r.vec_y, r.vec_z};
               quat_rotation(r.quat_w, r.quat_x, r.quat_y, r.quat_z);
               mm = mat;
               if (pos[2] <= off_alt) begin
                  for (int i = 0; i < 3; i++)
                     v[i] = sat32(v[i] + sat32(rnd(mm[i][0] * offx, QF)));
               end
               // camera axes to body axes
               be[0] = sat32(-v[1]);
               be[1] = sat32(-v[0]);
               be[2] = sat32(-v[2]);
               quat_rotation(att[0], att[1], att[2], att[3]);
               for (int i = 0; i < 3; i++)
                  af[i] = sat32(rnd(mat[i][0] * be[0] + mat[i][1] * be[1]
                                    + mat[i][2] * be[2], QF));
               if (lock)
                  for (int i = 0; i < 3; i++) tgt[i] = to_cm(af[i] + pos[i]);
               al = mag(af[0]) < thr && mag(af[1]) < thr;
               if (al) begin
                  if (pos[2] >= dmin) alt_cm = to_cm(pos[2] - dstep);
               end else begin
                  alt_cm = to_cm(pos[2]);
                  lock = 0;
               end
               if (count + 1 >= period) begin
                  lock = 1;
                  count = 0;
               end else begin
                  count = count + 1;
               end
               sp.sp_x = CM_W'(tgt[0]);
               sp.sp_y = CM_W'(tgt[1]);
               sp.sp_z = CM_W'(alt_cm);
               sp.aligned = al;
               sp.lock_state = lock;
               setpoints_due.push_back(sp);
            end
            default: ;
         endcase
      endfunction

      function void check_setpoint(setpoint_type got);
         setpoint_type exp_sp;
         if (setpoints_due.size() == 0) begin
            $display("%0t: unexpected setpoint %h", $time, got);
            errors++;
            return;
         end
         exp_sp = setpoints_due.pop_front();
         if (got.sp_x !== exp_sp.sp_x) begin
            $display("%0t: setpoint_x_cm expected %0d got %0d", $time, exp_sp.sp_x, got.sp_x);
            errors++;
         end
         if (got.sp_y !== exp_sp.sp_y) begin
            $display("%0t: setpoint_y_cm expected %0d got %0d", $time, exp_sp.sp_y, got.sp_y);
            errors++;
         end
         if (got.sp_z !== exp_sp.sp_z) begin
            $display("%0t: setpoint_z_cm expected %0d got %0d", $time, exp_sp.sp_z, got.sp_z);
            errors++;
         end
         if (got.aligned !== exp_sp.aligned) begin
            $display("%0t: aligned expected %0b got %0b", $time, exp_sp.aligned, got.aligned);
            errors++;
         end
         if (got.lock_state !== exp_sp.lock_state) begin
            $display("%0t: lock_state expected %0b got %0b", $time,
                     exp_sp.lock_state, got.lock_state);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   mls_if #(.PAYLOAD_W($bits(req_item_type))) req_ch ();
   mls_if #(.PAYLOAD_W($bits(setpoint_type))) rsp_ch ();

   setpoint_scoreboard sb = new();
   int hold_start = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int stall_cnt = 0;

   marker_landing_setpoint i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
   end

   initial begin
      #10ms;
      $display("marker_landing_setpoint test failed");
      $finish;
   end

   // receiver: stall pattern is redrawn at random, plus a long hold-off on demand
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_setpoint(rsp_ch.payload);
      stall_cnt++;
      if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_start) begin
         hold_start = 0;
         hold_left = 500;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 0;
      end else begin
         case (stall_mode)
            0, 3: rsp_ch.ready <= 1;
            1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_request(req_item_type r);
      req_ch.valid <= 1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(r);
   endtask

   task automatic idle_sender(int n);
      if (n > 0) begin
         req_ch.valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_all_setpoints();
      req_ch.valid <= 0;
      @(posedge clock);
      while (sb.setpoints_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 0;
      sb.set_reg(idx, d);
   endtask

   function automatic logic signed [31:0] rand_pos();
      case ($urandom_range(0, 11))
         0: return $urandom;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3, 4: return int'($urandom_range(0, 26214)) - 13107;
         default: return int'($urandom_range(0, 393216)) - 196608;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_quat();
      case ($urandom_range(0, 7))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2, 3: return 16'(int'($urandom_range(0, 2000)) - 1000);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic req_item_type rand_request();
      req_item_type r;
      int k;
      k = $urandom_range(0, 19);
      r.mode = k < 3 ? MODE_ATT : k < 7 ? MODE_POS : k < 19 ? MODE_DET : 2'd3;
      r.vec_x = rand_pos();
      r.vec_y = rand_pos();
      r.vec_z = rand_pos();
      if (r.mode == MODE_POS && $urandom_range(0, 2) != 0)
         r.vec_z = $urandom_range(0, 5 * 65536);
      r.quat_w = rand_quat();
      r.quat_x = rand_quat();
      r.quat_y = rand_quat();
      r.quat_z = rand_quat();
      // near-identity attitude keeps the drone aligned now and then
      if (r.mode == MODE_ATT && $urandom_range(0, 1) == 1) begin
         r.quat_w = 16'sd16384;
         r.quat_x = 16'(int'($urandom_range(0, 400)) - 200);
         r.quat_y = 16'(int'($urandom_range(0, 400)) - 200);
         r.quat_z = 16'(int'($urandom_range(0, 400)) - 200);
      end
      return r;
   endfunction

   function automatic req_item_type mk(logic [1:0] m, logic signed [31:0] x, y, z,
                                       logic signed [15:0] w, qx, qy, qz);
      req_item_type r;
      r = '{m, x, y, z, w, qx, qy, qz};
      return r;
   endfunction

   task automatic random_config(int phase);
      case (phase % 4)
         0: begin
            write_reg(REG_OFF_ALT, 32'h7fffffff);
            write_reg(REG_ALIGN, 32'h7fffffff);
            write_reg(REG_DESC_MIN, '0);
            write_reg(REG_DESC_STEP, 32'h7fffffff);
            write_reg(REG_LOCK_PER, 32'd1);
            write_reg(REG_OFFSET_X, 32'h7fffffff);
         end
         1: begin
            write_reg(REG_OFF_ALT, '0);
            write_reg(REG_ALIGN, '0);
            write_reg(REG_DESC_MIN, 32'hffffffff);
            write_reg(REG_DESC_STEP, '0);
            write_reg(REG_LOCK_PER, 32'd255);
            write_reg(REG_OFFSET_X, 32'h80000000);
         end
         default: begin
            write_reg(REG_OFF_ALT, $urandom_range(0, 5 * 65536) | ($urandom_range(0, 1) << 31));
            write_reg(REG_ALIGN, $urandom_range(0, 65536 * 4));
            write_reg(REG_DESC_MIN, $urandom_range(0, 65536 * 2));
            write_reg(REG_DESC_STEP, $urandom_range(0, 65536 * 3));
            write_reg(REG_LOCK_PER, $urandom_range(0, 20));
            write_reg(REG_OFFSET_X, int'($urandom_range(0, 131072)) - 65536);
         end
      endcase
   endtask

   initial begin
      req_item_type dir[$];
      int burst;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      dir.push_back(mk(MODE_DET, 1000, -2000, 3000, 16384, 0, 0, 0));
      dir.push_back(mk(MODE_POS, 0, 0, 32'sd65536, 0, 0, 0, 0));
      dir.push_back(mk(MODE_DET, 0, 0, 0, 16384, 0, 0, 0));
      dir.push_back(mk(MODE_DET, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                       -16384, 16384, -16384, 16384));
      dir.push_back(mk(MODE_DET, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                       16384, 16384, 16384, 16384));
      dir.push_back(mk(MODE_ATT, 0, 0, 0, 0, 16384, 0, 0));
      dir.push_back(mk(MODE_DET, 5000, 5000, 100000, 0, 0, 16384, 0));
      dir.push_back(mk(2'd3, -1, -1, -1, -1, -1, -1, -1));
      dir.push_back(mk(MODE_POS, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0));
      dir.push_back(mk(MODE_DET, 100, 100, 100, -16384, -16384, -16384, -16384));
      dir.push_back(mk(MODE_ATT, 0, 0, 0, -16384, -16384, 16384, 16384));
      dir.push_back(mk(MODE_DET, -65536, 65536, 0, 16384, 0, 0, 16384));
      dir.push_back(mk(MODE_ATT, 0, 0, 0, 16384, 0, 0, 0));
      dir.push_back(mk(MODE_POS, 1000, 1000, 32'sd400000, 0, 0, 0, 0));
      dir.push_back(mk(MODE_DET, 0, 0, 0, 16384, 0, 0, 0));
      dir.push_back(mk(MODE_POS, 0, 0, 32'sd10000, 0, 0, 0, 0));
      dir.push_back(mk(MODE_DET, 32768, 0, 0, 16384, 0, 0, 0));
      dir.push_back(mk(MODE_DET, 0, 0, 0, 16384, 0, 0, 0));
      foreach (dir[i]) send_request(dir[i]);
      wait_all_setpoints();

      for (int phase = 0; phase < 8; phase++) begin
         random_config(phase);
         if (phase == 5) write_reg(REG_LOCK_PER, '0);
         for (int n = 0; n < 200; ) begin
            burst = $urandom_range(1, 20);
            if (phase == 2 && n == 0) hold_start = 1;
            for (int b = 0; b < burst; b++) begin
               send_request(rand_request());
               n++;
            end
            if (phase != 3) idle_sender($urandom_range(0, 12));
         end
         wait_all_setpoints();
      end

      if (sb.errors == 0) begin
         $display("marker_landing_setpoint test passed");
      end else begin
         $display("marker_landing_setpoint test failed");
      end
      $finish;
   end

endmodule
